/* hdl/closest_point_on_polygon_ring_macros.svh */
// assertion macros for the closest point on polygon ring block
// used by the checker module only
`ifndef CLOSEST_POINT_ON_POLYGON_RING_MACROS_SVH
`define CLOSEST_POINT_ON_POLYGON_RING_MACROS_SVH

// checked only out of reset
`define CPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define CPR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/cpr_pkg.sv */
// shared types and constants for the closest point on polygon ring block
// no dependencies
package cpr_pkg;

  localparam int CW = 24;          // coordinate width
  localparam int TF = 24;          // fraction bits of t
  localparam int MW = 26;          // multiplier operand width
  localparam int PW = 2 * MW;      // product width
  localparam int DW = 50;          // divider operand width
  localparam int CNTW = 5;         // divider step counter width
  localparam int OUT_TDATA_W = 104;

  localparam logic [1:0] REG_QUERY_X = 2'd0;
  localparam logic [1:0] REG_QUERY_Y = 2'd1;
  localparam logic [1:0] REG_RING_OPEN = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_M0, S_M1, S_M2, S_M3, S_M4, S_TQ, S_DIV,
    S_C0, S_C1, S_C2, S_C3, S_C4, S_NEXT, S_OUT
  } state_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
  } div_req_t;

endpackage

/* hdl/cpr_mul.sv */
// shared signed multiplier with registered product
// depends on cpr_pkg
module cpr_mul (
  input  logic                              clk,
  input  logic signed [cpr_pkg::MW-1:0]     op_a,
  input  logic signed [cpr_pkg::MW-1:0]     op_b,
  output logic signed [cpr_pkg::PW-1:0]     prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

/* hdl/cpr_div.sv */
// radix-2 restoring divider, one quotient bit per cycle, for num < den
// depends on cpr_pkg
module cpr_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cpr_pkg::div_req_t         req,
  output logic                      done_r,
  output logic [cpr_pkg::TF-1:0]    quot_r
);

  logic [cpr_pkg::DW-1:0]   rem_r, rem_nxt;
  logic [cpr_pkg::DW-1:0]   den_r;
  logic [cpr_pkg::CNTW-1:0] cnt_r;
  logic                     busy_r;
  logic [cpr_pkg::DW:0]     shifted;
  logic                     take;

  always_comb begin
    shifted = {rem_r, 1'b0};
    take    = shifted >= {1'b0, den_r};
    rem_nxt = take ? cpr_pkg::DW'(shifted - {1'b0, den_r}) : shifted[cpr_pkg::DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + cpr_pkg::CNTW'(1);
        if (cnt_r == cpr_pkg::CNTW'(cpr_pkg::TF - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.num;
      den_r  <= req.den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[cpr_pkg::TF-2:0], take};
    end
  end

endmodule

/* hdl/closest_point_on_polygon_ring.sv */
// an edge runs setup (S_PREP), products (S_M0 to S_M4), the t quotient (S_TQ), a divide (S_DIV)
// unless t clamps, then finish (S_C0 to S_C4, S_NEXT); the last vertex of an open ring runs its
// own edge and the closing edge, then the output state; no new vertex is taken until the edges
// of the last one are done; the first vertex of a ring starts no edge; in_tready low while an
// edge is worked; the output cycle waits while an earlier result transaction is still stalled
// rst_n synchronous active low: clears configuration registers, ring state and output valid
module closest_point_on_polygon_ring (
  input  logic                               clk,
  input  logic                               rst_n,
  // config write port
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [cpr_pkg::CW-1:0]             cfg_wdata,
  // vertex transactions
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [2*cpr_pkg::CW-1:0]           in_tdata,  // vertex_x, vertex_y
  input  logic                               in_tlast,  // last_vertex
  // result transactions
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cpr_pkg::OUT_TDATA_W-1:0]    out_tdata, // closest_x, closest_y, distance_squared, pad
  output logic                               out_tuser  // found
);

  localparam int CW = cpr_pkg::CW;
  localparam int MW = cpr_pkg::MW;
  localparam int PW = cpr_pkg::PW;
  localparam int DW = cpr_pkg::DW;
  localparam int TF_W = cpr_pkg::TF + 1;

  // configuration registers
  logic signed [CW-1:0] qx_r, qy_r;
  logic                 open_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r   <= '0;
      qy_r   <= '0;
      open_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cpr_pkg::REG_QUERY_X:   qx_r   <= cfg_wdata;
        cpr_pkg::REG_QUERY_Y:   qy_r   <= cfg_wdata;
        cpr_pkg::REG_RING_OPEN: open_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  cpr_pkg::state_t state_r, state_nxt;

  // ring state
  logic signed [CW-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                 have_prev_r, have_best_r, last_r, close_pend_r;
  logic signed [CW-1:0] best_x_r, best_y_r;
  logic [DW-1:0]        best_d_r;

  // edge datapath
  logic signed [CW-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [CW:0]   dx_r, dy_r, px_r, py_r;
  logic signed [PW-1:0] acc_r;
  logic [TF_W-1:0]      tq_r;
  logic signed [CW-1:0] cx_r, cy_r;

  // output register
  logic                              ovalid_r;
  logic [cpr_pkg::OUT_TDATA_W-1:0]   odata_r;
  logic                              ofound_r;

  // shared multiplier
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_r;

  cpr_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  // divider
  cpr_pkg::div_req_t     div_req;
  logic                  div_done;
  logic [cpr_pkg::TF-1:0] div_quot;

  cpr_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (div_req),
    .done_r (div_done),
    .quot_r (div_quot)
  );

  logic                 in_acc;
  logic signed [CW-1:0] vx, vy;
  logic signed [PW-1:0] acc_sum, scaled;
  logic signed [MW-1:0] tq_op;
  logic signed [CW:0]   ex, ey;
  logic signed [MW-1:0] coord_sum;

  assign vx     = in_tdata[CW-1:0];
  assign vy     = in_tdata[2*CW-1:CW];
  assign in_acc = in_tvalid && in_tready;
  assign in_tready = (state_r == cpr_pkg::S_IDLE);

  assign acc_sum    = acc_r + prod_r;
  // rounding: add one half, then floor by arithmetic shift
  assign scaled     = (prod_r + PW'(1 <<< (cpr_pkg::TF - 1))) >>> cpr_pkg::TF;
  assign tq_op      = MW'(tq_r);
  assign ex         = (CW+1)'(cx_r) - (CW+1)'(qx_r);
  assign ey         = (CW+1)'(cy_r) - (CW+1)'(qy_r);

  logic [DW-1:0]        den_r;
  logic signed [PW-1:0] num_w;
  logic                 edge_num_pos, edge_den_zero, edge_ge;

  assign num_w         = acc_r;
  assign edge_den_zero = (den_r == '0);
  assign edge_num_pos  = !num_w[PW-1] && (num_w != '0);
  assign edge_ge       = (num_w >= PW'(den_r));

  always_comb begin
    state_nxt     = state_r;
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.num   = acc_r[DW-1:0];
    div_req.den   = den_r;
    coord_sum     = '0;
    unique case (state_r)
      cpr_pkg::S_IDLE: begin
        if (in_acc) begin
          if (have_prev_r) state_nxt = cpr_pkg::S_PREP;
          else if (in_tlast) state_nxt = cpr_pkg::S_OUT;
        end
      end
      cpr_pkg::S_PREP: state_nxt = cpr_pkg::S_M0;
      cpr_pkg::S_M0: begin
        mul_a = MW'(dx_r); mul_b = MW'(dx_r);
        state_nxt = cpr_pkg::S_M1;
      end
      cpr_pkg::S_M1: begin
        mul_a = MW'(dy_r); mul_b = MW'(dy_r);
        state_nxt = cpr_pkg::S_M2;
      end
      cpr_pkg::S_M2: begin
        mul_a = MW'(px_r); mul_b = MW'(dx_r);
        state_nxt = cpr_pkg::S_M3;
      end
      cpr_pkg::S_M3: begin
        mul_a = MW'(py_r); mul_b = MW'(dy_r);
        state_nxt = cpr_pkg::S_M4;
      end
      cpr_pkg::S_M4: state_nxt = cpr_pkg::S_TQ;
      cpr_pkg::S_TQ: begin
        // clamp cases skip the divider
        if (!edge_den_zero && edge_num_pos && !edge_ge) begin
          div_req.start = 1'b1;
          state_nxt = cpr_pkg::S_DIV;
        end else begin
          state_nxt = cpr_pkg::S_C0;
        end
      end
      cpr_pkg::S_DIV: if (div_done) state_nxt = cpr_pkg::S_C0;
      cpr_pkg::S_C0: begin
        mul_a = MW'(dx_r); mul_b = tq_op;
        state_nxt = cpr_pkg::S_C1;
      end
      cpr_pkg::S_C1: begin
        mul_a = MW'(dy_r); mul_b = tq_op;
        state_nxt = cpr_pkg::S_C2;
      end
      cpr_pkg::S_C2: begin
        mul_a = MW'(ex); mul_b = MW'(ex);
        state_nxt = cpr_pkg::S_C3;
      end
      cpr_pkg::S_C3: begin
        mul_a = MW'(ey); mul_b = MW'(ey);
        state_nxt = cpr_pkg::S_C4;
      end
      cpr_pkg::S_C4: state_nxt = cpr_pkg::S_NEXT;
      cpr_pkg::S_NEXT: begin
        if (close_pend_r) state_nxt = cpr_pkg::S_PREP;
        else if (last_r) state_nxt = cpr_pkg::S_OUT;
        else state_nxt = cpr_pkg::S_IDLE;
      end
      cpr_pkg::S_OUT: if (!ovalid_r || out_tready) state_nxt = cpr_pkg::S_IDLE;
      default: state_nxt = cpr_pkg::S_IDLE;
    endcase
    // closest coordinate: a plus rounded d*t
    coord_sum = (state_r == cpr_pkg::S_C2) ? MW'(ay_r) + MW'(scaled) : MW'(ax_r) + MW'(scaled);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cpr_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // ring control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r  <= 1'b0;
      have_best_r  <= 1'b0;
      last_r       <= 1'b0;
      close_pend_r <= 1'b0;
      first_x_r    <= '0;
      first_y_r    <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      best_x_r     <= '0;
      best_y_r     <= '0;
      best_d_r     <= '0;
      ovalid_r     <= 1'b0;
    end else begin
      // a new result in the output cycle replaces the one taken in that cycle
      if (ovalid_r && out_tready && state_r != cpr_pkg::S_OUT) ovalid_r <= 1'b0;
      if (in_acc) begin
        if (!have_prev_r) begin
          first_x_r <= vx;
          first_y_r <= vy;
        end
        prev_x_r     <= vx;
        prev_y_r     <= vy;
        have_prev_r  <= 1'b1;
        last_r       <= in_tlast;
        close_pend_r <= in_tlast && open_r && have_prev_r;
      end
      if (state_r == cpr_pkg::S_NEXT && close_pend_r) close_pend_r <= 1'b0;
      // keep the first edge on a tie
      if (state_r == cpr_pkg::S_C4 &&
          (!have_best_r || acc_sum[DW-1:0] < best_d_r)) begin
        best_x_r    <= cx_r;
        best_y_r    <= cy_r;
        best_d_r    <= acc_sum[DW-1:0];
        have_best_r <= 1'b1;
      end
      if (state_r == cpr_pkg::S_OUT) begin
        if (!ovalid_r || out_tready) begin
          ovalid_r    <= 1'b1;
          have_prev_r <= 1'b0;
          have_best_r <= 1'b0;
          last_r      <= 1'b0;
          first_x_r   <= '0;
          first_y_r   <= '0;
          prev_x_r    <= '0;
          prev_y_r    <= '0;
          best_x_r    <= '0;
          best_y_r    <= '0;
          best_d_r    <= '0;
        end
      end
    end
  end

  // edge datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_r <= vx;
      ay_r <= vy;
      bx_r <= prev_x_r;
      by_r <= prev_y_r;
    end
    if (state_r == cpr_pkg::S_NEXT) begin
      // closing edge runs from the last vertex back to the first
      bx_r <= first_x_r;
      by_r <= first_y_r;
    end
    unique case (state_r)
      cpr_pkg::S_PREP: begin
        dx_r <= (CW+1)'(bx_r) - (CW+1)'(ax_r);
        dy_r <= (CW+1)'(by_r) - (CW+1)'(ay_r);
        px_r <= (CW+1)'(qx_r) - (CW+1)'(ax_r);
        py_r <= (CW+1)'(qy_r) - (CW+1)'(ay_r);
      end
      cpr_pkg::S_M1: acc_r <= prod_r;
      cpr_pkg::S_M2: den_r <= DW'(acc_sum);
      cpr_pkg::S_M3: acc_r <= prod_r;
      cpr_pkg::S_M4: acc_r <= acc_sum;
      cpr_pkg::S_TQ: begin
        if (edge_den_zero || !edge_num_pos) tq_r <= '0;
        else if (edge_ge) tq_r <= TF_W'(1 <<< cpr_pkg::TF);
      end
      cpr_pkg::S_DIV: if (div_done) tq_r <= {1'b0, div_quot};
      cpr_pkg::S_C1: cx_r <= coord_sum[CW-1:0];
      cpr_pkg::S_C2: cy_r <= coord_sum[CW-1:0];
      cpr_pkg::S_C3: acc_r <= prod_r;
      cpr_pkg::S_OUT: begin
        if (!ovalid_r || out_tready) begin
          odata_r  <= {7'd0, best_d_r[2*CW:0], best_y_r, best_x_r};
          ofound_r <= have_best_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ofound_r;

endmodule

/* hdl/cpr_checker.sv */
// port-level checker for the closest point on polygon ring block, with bind
// depends on closest_point_on_polygon_ring_macros.svh
`include "closest_point_on_polygon_ring_macros.svh"

module cpr_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic         out_tuser
);

  `CPR_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `CPR_ASSERT(a_not_found_zero, out_tvalid && !out_tuser |-> out_tdata == '0, "empty ring result not zero")
  `CPR_ASSERT(a_busy_after_last, in_tvalid && in_tready && in_tlast |=> !in_tready, "took a vertex while finishing a ring")
  `CPR_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind closest_point_on_polygon_ring cpr_checker u_cpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps
// testbench for closest_point_on_polygon_ring: streams polygon rings, predicts the
// nearest boundary point for each ring and checks every result transaction
// depends on cpr_pkg and the block itself
module testbench;

  localparam int CW = cpr_pkg::CW;
  localparam int TF = cpr_pkg::TF;
  localparam int OUT_TDATA_W = cpr_pkg::OUT_TDATA_W;

  typedef struct {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [48:0]   dsq;
    logic          found;
  } nearest_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [1:0]      cfg_index = cpr_pkg::REG_QUERY_X;
  logic [CW-1:0]   cfg_wdata = '0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [2*CW-1:0] in_tdata = '0;   // vertex_x, vertex_y
  logic            in_tlast = 1'b0; // last_vertex
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata; // closest_x, closest_y, distance_squared, pad
  logic            out_tuser;        // found

  // predictor copy of registers and ring state
  longint   qry_x, qry_y;
  bit       ring_open;
  longint   first_x, first_y, prev_x, prev_y, best_x, best_y, best_d;
  bit       have_prev, have_best;
  nearest_t nearest_q[$];

  int  errors = 0;
  bit  steady = 1'b0;  // when set neither side idles

  closest_point_on_polygon_ring i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver stalls at random, unless in a steady stretch
  always @(posedge clk) begin
    out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 18);
  end

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // checker: each result transaction against the oldest prediction
  always @(posedge clk) begin
    nearest_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (nearest_q.size() == 0) begin
        report("unexpected result", out_tuser, 0);
      end else begin
        e = nearest_q.pop_front();
        if (out_tdata[CW-1:0] !== e.px)
          report("closest_x", longint'($signed(out_tdata[CW-1:0])), longint'($signed(e.px)));
        if (out_tdata[2*CW-1:CW] !== e.py)
          report("closest_y", longint'($signed(out_tdata[2*CW-1:CW])),
                 longint'($signed(e.py)));
        if (out_tdata[2*CW+48:2*CW] !== e.dsq)
          report("distance_squared", out_tdata[2*CW+48:2*CW], e.dsq);
        if (out_tuser !== e.found)
          report("found", out_tuser, e.found);
      end
    end
  end

  task automatic clear_ring();
    first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
    best_x = 0; best_y = 0; best_d = 0;
    have_prev = 0; have_best = 0;
  endtask

  task automatic ref_reset_pred();
    qry_x = 0; qry_y = 0; ring_open = 0;
    clear_ring();
  endtask

  // project the query point onto edge a..b and keep the nearest candidate
  task automatic try_edge(longint ax, longint ay, longint bx, longint by);
    longint dx, dy, num, den, tq, cx, cy, ex, ey, d;
    logic [127:0] wide_num;
    dx = bx - ax; dy = by - ay;
    den = dx * dx + dy * dy;
    num = (qry_x - ax) * dx + (qry_y - ay) * dy;
    tq = 0;
    if (den != 0 && num > 0) begin
      if (num >= den) begin
        tq = longint'(1) << TF;
      end else begin
        wide_num = 128'(num) << TF;
        tq = longint'(wide_num / 128'(den));
      end
    end
    // round to nearest, ties toward plus infinity
    cx = ax + ((dx * tq + (longint'(1) << (TF - 1))) >>> TF);
    cy = ay + ((dy * tq + (longint'(1) << (TF - 1))) >>> TF);
    ex = cx - qry_x; ey = cy - qry_y;
    d = ex * ex + ey * ey;
    if (!have_best || d < best_d) begin
      best_x = cx; best_y = cy; best_d = d; have_best = 1;
    end
  endtask

  task automatic predict_vertex(logic [CW-1:0] vx_raw, logic [CW-1:0] vy_raw, bit last);
    longint vx, vy;
    bit two_or_more;
    nearest_t e;
    vx = longint'($signed(vx_raw));
    vy = longint'($signed(vy_raw));
    two_or_more = have_prev;
    if (have_prev) begin
      try_edge(vx, vy, prev_x, prev_y);
    end else begin
      first_x = vx; first_y = vy;
    end
    prev_x = vx; prev_y = vy; have_prev = 1;
    if (last) begin
      if (two_or_more && ring_open) try_edge(vx, vy, first_x, first_y);
      if (have_best) begin
        e.px = best_x[CW-1:0]; e.py = best_y[CW-1:0];
        e.dsq = best_d[48:0]; e.found = 1'b1;
      end else begin
        e.px = '0; e.py = '0; e.dsq = '0; e.found = 1'b0;
      end
      nearest_q.push_back(e);
      clear_ring();
    end
  endtask

  // one vertex transaction; valid stays high into the next send unless a gap is drawn
  task automatic send_vertex(longint x, longint y, bit last);
    if (!steady && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y[CW-1:0], x[CW-1:0]};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_vertex(x[CW-1:0], y[CW-1:0], last);
  endtask

  // wait for all results, then let the edge pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_query(longint x, longint y, bit open);
    cfg_we <= 1'b1; cfg_index <= cpr_pkg::REG_QUERY_X; cfg_wdata <= x[CW-1:0];
    @(posedge clk);
    cfg_index <= cpr_pkg::REG_QUERY_Y; cfg_wdata <= y[CW-1:0];
    @(posedge clk);
    cfg_index <= cpr_pkg::REG_RING_OPEN; cfg_wdata <= CW'(open);
    @(posedge clk);
    cfg_we <= 1'b0;
    qry_x = longint'($signed(x[CW-1:0]));
    qry_y = longint'($signed(y[CW-1:0]));
    ring_open = open;
  endtask

  localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint CMIN = -(longint'(1) << (CW - 1));

  task automatic test_degenerate();
    set_query(0, 0, 1'b1);
    send_vertex(7, -3, 1'b1);             // lone vertex, nothing found
    send_vertex(3, 3, 1'b0);              // zero-length edge
    send_vertex(3, 3, 1'b1);
    send_vertex(1, 0, 1'b0);              // first edge passes through the query point
    send_vertex(-1, 0, 1'b0);
    send_vertex(0, 2, 1'b1);
    drain();
  endtask

  task automatic test_projection();
    set_query(0, 0, 1'b0);
    send_vertex(-10, 5, 1'b0);            // interior projection
    send_vertex(10, 5, 1'b1);
    send_vertex(5, 0, 1'b0);              // clamps at each end
    send_vertex(10, 0, 1'b1);
    send_vertex(10, 0, 1'b0);
    send_vertex(5, 0, 1'b1);
    send_vertex(-3, 7, 1'b0);             // rounding of a fractional t
    send_vertex(4, -2, 1'b0);
    send_vertex(9, 1, 1'b1);
    drain();
    set_query(2, 1, 1'b1);                // closing edge wins
    send_vertex(0, 10, 1'b0);
    send_vertex(10, 10, 1'b0);
    send_vertex(3, 0, 1'b1);
    drain();
  endtask

  task automatic test_extremes();
    set_query(CMAX, CMAX, 1'b1);
    send_vertex(CMIN, CMIN, 1'b0);
    send_vertex(CMIN, CMAX, 1'b0);
    send_vertex(CMAX, CMIN, 1'b1);
    drain();
    set_query(CMIN, CMIN, 1'b0);
    send_vertex(CMAX, CMAX, 1'b0);
    send_vertex(CMIN, CMAX, 1'b1);
    send_vertex(CMAX, CMIN, 1'b0);
    send_vertex(CMAX, CMAX, 1'b1);
    drain();
  endtask

  function automatic longint rand_coord(bit near, longint center);
    longint v;
    if (!near) return longint'($signed(CW'($urandom)));
    v = center + $urandom_range(0, 40) - 20;
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v;
  endfunction

  // rings of random length, each either near the given query point or anywhere in range
  task automatic test_random_rings(int n_items, longint qx, longint qy, bit open);
    int sent, len;
    bit near;
    set_query(qx, qy, open);
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
      near = $urandom_range(1);
      for (int k = 0; k < len; k++) begin
        send_vertex(rand_coord(near, qx), rand_coord(near, qy), k == len - 1);
      end
      sent += len;
    end
    drain();
  endtask

  initial begin
    ref_reset_pred();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_degenerate();
    test_projection();
    test_extremes();
    test_random_rings(200, longint'($signed(CW'($urandom))), longint'($signed(CW'($urandom))),
                      1'b0);
    test_random_rings(200, CMAX, CMIN, 1'b1);
    steady = 1'b1;                        // no idling on either side here
    test_random_rings(150, 0, 0, 1'b1);
    steady = 1'b0;
    test_random_rings(200, CMIN, CMAX, 1'b0);
    test_random_rings(200, longint'($urandom_range(0, 1000)),
                      -longint'($urandom_range(0, 1000)), 1'b1);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/cpr_pkg.sv
hdl/cpr_mul.sv
hdl/cpr_div.sv
hdl/closest_point_on_polygon_ring.sv
hdl/cpr_checker.sv
sim/testbench.sv
